[rtl/core/fra_pkg.sv]
// Package for the flow rate target allocator: transaction structs, codes and constants.
// Used by flow_rate_target_allocator and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;

	localparam int NUM_FLOWS_DEF = 64;
	localparam int RATE_W        = 16;
	localparam int MARGIN_W      = 12;
	localparam int CNT_OUT_W     = 7;
	localparam int UNUSED_W      = 22;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [RATE_W-1:0]   TARGET_RESET = 16'd12500;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd10;
	localparam logic [RATE_W-1:0]   RATE_MAX     = 16'hFFFF;
	localparam logic [UNUSED_W-1:0] UNUSED_MAX   = 22'h3FFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN        = 2'd1;

	// operation codes
	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_JOIN   = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// tick action codes
	localparam logic [1:0] ACT_NONE       = 2'd0;
	localparam logic [1:0] ACT_EQUALIZE   = 2'd1;
	localparam logic [1:0] ACT_REDISTRIB  = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [5:0]        slot;
		logic              flow_active;
		logic              flow_small;
		logic [RATE_W-1:0] measured_rate;
	} cmd_t;

	typedef struct packed {
		logic [RATE_W-1:0]    target_rate;
		logic [CNT_OUT_W-1:0] big_flows;
		logic [CNT_OUT_W-1:0] small_flows;
		logic [CNT_OUT_W-1:0] saturated_flows;
		logic [UNUSED_W-1:0]  unused_total;
		logic [1:0]           action;
		logic [RATE_W-1:0]    share;
	} rsp_t;

	// one flow table entry
	typedef struct packed {
		logic              active;
		logic              small_flow;
		logic [RATE_W-1:0] measured;
		logic [RATE_W-1:0] target;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[rtl/core/fra_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/flow_rate_target_allocator.sv]
// Flow rate target allocator top level: flow table RAM, sweep control and serial divider.
// Depends on fra_pkg and fra_ram.
//
//  channel   | signals                          | transaction
//  ----------+----------------------------------+------------------------------
//  command   | start, busy, cmd                 | start && !busy at rising edge
//  result    | done, result                     | done high for one cycle
//  config    | cfg_we, cfg_index, cfg_wdata     | cfg_we at rising edge
//
// Join is answered from S_IDLE. Update and read go through S_RMW or S_READ, then S_FIN
// (one table read port, registered data). Tick with action: read sweep, S_DECIDE, 22-step
// divider, write-back sweep, S_FIN; without action S_DECIDE goes to S_FIN; busy stays high.
// After reset the table is cleared one entry a cycle, busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module flow_rate_target_allocator
	import fra_pkg::*;
#(
	parameter int NUM_FLOWS = NUM_FLOWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire cmd_t                  cmd,
	output logic                       done,
	output rsp_t                       result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW  = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int PW  = AW + 1;
	localparam int CW  = $clog2(NUM_FLOWS + 1);
	localparam int UW  = (RATE_W + AW > UNUSED_W) ? RATE_W + AW : UNUSED_W;
	localparam int DCW = $clog2(UNUSED_W);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_RMW    = 9'b000000100,
		S_READ   = 9'b000001000,
		S_SWEEP  = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_DIV    = 9'b001000000,
		S_APPLY  = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [RATE_W-1:0]   link_cap_q;
	logic [MARGIN_W-1:0] margin_q;
	logic                pending_q;
	cmd_t                cmd_q;
	logic                in_range_q;

	logic [PW-1:0]       ptr_q;
	logic                rvalid_s1;
	logic [AW-1:0]       addr_s1;

	logic [CW-1:0]       acc_big_q;
	logic [CW-1:0]       acc_small_q;
	logic [CW-1:0]       acc_sat_q;
	logic [UW-1:0]       acc_unused_q;

	logic [CNT_OUT_W-1:0] st_big_q;
	logic [CNT_OUT_W-1:0] st_small_q;
	logic [CNT_OUT_W-1:0] st_sat_q;
	logic [UNUSED_W-1:0]  st_unused_q;
	logic [1:0]           st_action_q;
	logic [RATE_W-1:0]    st_share_q;

	logic [CW-1:0]        div_rem_q;
	logic [UNUSED_W-1:0]  div_quo_q;
	logic [CW-1:0]        div_den_q;
	logic [DCW-1:0]       div_cnt_q;

	rsp_t                 res_q;
	logic                 done_q;

	// RAM ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	logic [AW-1:0]        ram_raddr;
	entry_t               ram_rdata;

	fra_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_FLOWS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic accept;
	logic slot_ok;
	logic ptr_live;
	logic sweep_last;

	assign accept     = start && (state_q == S_IDLE);
	assign slot_ok    = (32'(cmd.slot) < NUM_FLOWS);
	assign ptr_live   = (32'(ptr_q) < NUM_FLOWS);
	assign sweep_last = !ptr_live && rvalid_s1;

	// per-entry sweep arithmetic
	logic [RATE_W:0]   adj;
	logic [RATE_W-1:0] floor_t;
	logic              unsat;
	logic [RATE_W-1:0] unused_d;
	logic [RATE_W:0]   grown;
	logic [RATE_W-1:0] new_target;

	assign adj      = {1'b0, ram_rdata.measured} + (RATE_W+1)'(margin_q);
	assign floor_t  = (ram_rdata.target > RATE_W'(margin_q)) ?
	                  ram_rdata.target - RATE_W'(margin_q) : '0;
	assign unsat    = adj < {1'b0, floor_t};
	assign unused_d = ram_rdata.target - ram_rdata.measured;
	assign grown    = {1'b0, ram_rdata.target} + {1'b0, st_share_q};

	always_comb begin
		if (st_action_q == ACT_EQUALIZE) begin
			new_target = st_share_q;
		end else if (adj >= {1'b0, ram_rdata.target}) begin
			new_target = grown[RATE_W] ? RATE_MAX : grown[RATE_W-1:0];
		end else begin
			new_target = adj[RATE_W-1:0];
		end
	end

	// tick decision
	logic [UNUSED_W-1:0] unused_cl;
	logic                do_eq;
	logic                do_redis;

	assign unused_cl = (acc_unused_q > UW'(UNUSED_MAX)) ? UNUSED_MAX :
	                   UNUSED_W'(acc_unused_q);
	assign do_eq     = (acc_big_q != '0) && pending_q;
	assign do_redis  = (acc_big_q != '0) && !pending_q && (acc_sat_q != '0) &&
	                   (unused_cl != '0);

	// divider step
	logic [CW:0] div_trial;
	assign div_trial = {div_rem_q, div_quo_q[UNUSED_W-1]} - {1'b0, div_den_q};

	// drive RAM address and write port
	always_comb begin
		ram_raddr = ptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_IDLE) begin
			ram_raddr = AW'(cmd.slot);
		end else if (state_q == S_READ) begin
			// hold the addressed entry on the read port until the result
			ram_raddr = AW'(cmd_q.slot);
		end
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[AW-1:0];
				ram_wdata = '{active: 1'b0, small_flow: 1'b0, measured: '0,
				              target: TARGET_RESET};
			end
			S_RMW: begin
				ram_we    = in_range_q;
				ram_waddr = AW'(cmd_q.slot);
				ram_wdata = '{active: cmd_q.flow_active, small_flow: cmd_q.flow_small,
				              measured: cmd_q.measured_rate, target: ram_rdata.target};
			end
			S_APPLY: begin
				ram_we           = rvalid_s1 && ram_rdata.active;
				ram_wdata.target = new_target;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_cap_q <= TARGET_RESET;
			margin_q   <= MARGIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LINK_CAPACITY) begin
				link_cap_q <= cfg_wdata;
			end else if (cfg_index == CFG_MARGIN) begin
				margin_q <= cfg_wdata[MARGIN_W-1:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			in_range_q <= slot_ok;
		end
		addr_s1 <= ptr_q[AW-1:0];
	end

	// control, sweep, divider and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			rvalid_s1    <= 1'b0;
			pending_q    <= 1'b0;
			acc_big_q    <= '0;
			acc_small_q  <= '0;
			acc_sat_q    <= '0;
			acc_unused_q <= '0;
			st_big_q     <= '0;
			st_small_q   <= '0;
			st_sat_q     <= '0;
			st_unused_q  <= '0;
			st_action_q  <= ACT_NONE;
			st_share_q   <= '0;
			div_rem_q    <= '0;
			div_quo_q    <= '0;
			div_den_q    <= '0;
			div_cnt_q    <= '0;
			res_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					// sweep reset values into the table
					ptr_q <= ptr_q + 1'b1;
					if (32'(ptr_q) == NUM_FLOWS - 1) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.operation)
							OP_UPDATE: state_q <= S_RMW;
							OP_READ:   state_q <= S_READ;
							OP_JOIN: begin
								pending_q <= 1'b1;
								done_q    <= 1'b1;
								res_q     <= '{target_rate: '0, big_flows: st_big_q,
								               small_flows: st_small_q,
								               saturated_flows: st_sat_q,
								               unused_total: st_unused_q,
								               action: st_action_q, share: st_share_q};
							end
							OP_TICK: begin
								ptr_q        <= '0;
								acc_big_q    <= '0;
								acc_small_q  <= '0;
								acc_sat_q    <= '0;
								acc_unused_q <= '0;
								state_q      <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_RMW: begin
					state_q <= S_FIN;
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_SWEEP: begin
					// issue reads, count the entry requested the cycle before
					if (ptr_live) begin
						ptr_q     <= ptr_q + 1'b1;
						rvalid_s1 <= 1'b1;
					end
					if (rvalid_s1 && ram_rdata.active) begin
						if (ram_rdata.small_flow) begin
							acc_small_q <= acc_small_q + 1'b1;
						end else begin
							acc_big_q <= acc_big_q + 1'b1;
							if (unsat) begin
								acc_unused_q <= acc_unused_q + UW'(unused_d);
							end else begin
								acc_sat_q <= acc_sat_q + 1'b1;
							end
						end
					end
					if (sweep_last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					st_big_q    <= CNT_OUT_W'(acc_big_q);
					st_small_q  <= CNT_OUT_W'(acc_small_q);
					st_sat_q    <= CNT_OUT_W'(acc_sat_q);
					st_unused_q <= unused_cl;
					div_rem_q   <= '0;
					div_cnt_q   <= '0;
					if (do_eq) begin
						pending_q   <= 1'b0;
						st_action_q <= ACT_EQUALIZE;
						div_quo_q   <= UNUSED_W'(link_cap_q);
						div_den_q   <= acc_big_q;
						state_q     <= S_DIV;
					end else if (do_redis) begin
						st_action_q <= ACT_REDISTRIB;
						div_quo_q   <= unused_cl;
						div_den_q   <= acc_sat_q;
						state_q     <= S_DIV;
					end else begin
						st_action_q <= ACT_NONE;
						st_share_q  <= '0;
						state_q     <= S_FIN;
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					if (!div_trial[CW]) begin
						div_rem_q <= div_trial[CW-1:0];
					end else begin
						div_rem_q <= {div_rem_q[CW-2:0], div_quo_q[UNUSED_W-1]};
					end
					div_quo_q <= {div_quo_q[UNUSED_W-2:0], !div_trial[CW]};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (32'(div_cnt_q) == UNUSED_W - 1) begin
						ptr_q   <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (ptr_q == '0 && !rvalid_s1) begin
						// latch the share once the quotient is complete
						st_share_q <= (div_quo_q > UNUSED_W'(RATE_MAX)) ? RATE_MAX :
						              div_quo_q[RATE_W-1:0];
					end
					if (ptr_live) begin
						ptr_q     <= ptr_q + 1'b1;
						rvalid_s1 <= 1'b1;
					end
					if (sweep_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					res_q   <= '{target_rate: '0, big_flows: st_big_q,
					             small_flows: st_small_q, saturated_flows: st_sat_q,
					             unused_total: st_unused_q, action: st_action_q,
					             share: st_share_q};
					if (cmd_q.operation == OP_READ && in_range_q) begin
						res_q.target_rate <= ram_rdata.target;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// checks
	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted transaction neither answered nor in progress");

	a_no_action_no_share: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.action == ACT_NONE) |-> (result.share == '0))
		else $error("share reported for a tick without action");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.action == ACT_NONE || result.action == ACT_EQUALIZE ||
		          result.action == ACT_REDISTRIB))
		else $error("bad action code");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_den_q != '0))
		else $error("divider started with zero divisor");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("table written while idle");

endmodule
`default_nettype wire

[bench/flow_rate_target_allocator_tb.sv]
// Self-checking bench for flow_rate_target_allocator: random and directed flow commands
// against an in-bench allocation predictor. Depends on fra_pkg and the allocator RTL.
`timescale 1ns / 1ps
module flow_rate_target_allocator_tb;
	import fra_pkg::*;

	localparam int NF        = 64;
	localparam int LIMIT     = 400000;
	localparam int SETTLE    = 2 * NF + 40;

	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	cmd_t                  cmd;
	logic                  done;
	rsp_t                  result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	flow_rate_target_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predicted flow table and settings
	logic              p_active [NF];
	logic              p_small [NF];
	logic [15:0]       p_meas [NF];
	logic [15:0]       p_tgt [NF];
	logic              p_eq_pending;
	logic [15:0]       p_capacity;
	logic [11:0]       p_margin;
	rsp_t              p_stats;

	cmd_t   cmd_queue[$];
	rsp_t   expected_rsp[$];
	int     errors = 0;
	int     cycles = 0;
	int     n_ticks = 0, n_eq = 0, n_redist = 0, n_checked = 0;
	logic   stim_done = 0;
	int     gap = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// sweep the predicted table as the block does on a tick
	function automatic void predict_tick();
		int unsigned big, smalls, sat, adj, floor_t, eq, t;
		longint unsigned unused, q;
		big = 0; smalls = 0; sat = 0; unused = 0;
		p_stats.action = ACT_NONE;
		p_stats.share = '0;
		for (int i = 0; i < NF; i++) begin
			if (p_active[i]) begin
				if (p_small[i]) begin
					smalls++;
				end else begin
					big++;
					adj = p_meas[i] + p_margin;
					floor_t = (p_tgt[i] > p_margin) ? p_tgt[i] - p_margin : 0;
					if (adj < floor_t)
						unused += p_tgt[i] - p_meas[i];
					else
						sat++;
				end
			end
		end
		if (unused > UNUSED_MAX) unused = UNUSED_MAX;
		if (big != 0) begin
			if (p_eq_pending) begin
				eq = p_capacity / big;
				p_eq_pending = 1'b0;
				for (int i = 0; i < NF; i++)
					if (p_active[i]) p_tgt[i] = eq[15:0];
				p_stats.action = ACT_EQUALIZE;
				p_stats.share = eq[15:0];
				n_eq++;
			end else if (sat != 0 && unused != 0) begin
				q = unused / sat;
				p_stats.share = (q > RATE_MAX) ? RATE_MAX : q[15:0];
				for (int i = 0; i < NF; i++) begin
					if (p_active[i]) begin
						adj = p_meas[i] + p_margin;
						if (adj >= p_tgt[i]) begin
							t = p_tgt[i] + p_stats.share;
							p_tgt[i] = (t > RATE_MAX) ? RATE_MAX : t[15:0];
						end else begin
							p_tgt[i] = adj[15:0];
						end
					end
				end
				p_stats.action = ACT_REDISTRIB;
				n_redist++;
			end
		end
		p_stats.big_flows = big[6:0];
		p_stats.small_flows = smalls[6:0];
		p_stats.saturated_flows = sat[6:0];
		p_stats.unused_total = unused[21:0];
		n_ticks++;
	endfunction

	// compute the expected response of one accepted command
	function automatic rsp_t predict_command(cmd_t c);
		rsp_t r;
		case (c.operation)
			OP_UPDATE: begin
				p_active[c.slot] = c.flow_active;
				p_small[c.slot] = c.flow_small;
				p_meas[c.slot] = c.measured_rate;
			end
			OP_JOIN: p_eq_pending = 1'b1;
			OP_TICK: predict_tick();
			default: ;
		endcase
		r = p_stats;
		r.target_rate = (c.operation == OP_READ) ? p_tgt[c.slot] : '0;
		return r;
	endfunction

	function automatic cmd_t make_cmd(int op, int slot, int act, int sm, int rate);
		cmd_t c;
		c.operation = op[1:0];
		c.slot = slot[5:0];
		c.flow_active = act[0];
		c.flow_small = sm[0];
		c.measured_rate = rate[15:0];
		return c;
	endfunction

	// random rate, biased toward the edges and the neighborhood of targets
	function automatic int pick_rate();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(0, 65535);
			default: return $urandom_range(0, 14000);
		endcase
	endfunction

	// drive commands: start held while items remain, random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else if (!(start && busy)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				start <= 1'b1;
				cmd <= cmd_queue.pop_front();
				if (!stim_done && $urandom_range(0, 5) == 0)
					gap <= $urandom_range(1, 12);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// predict at acceptance of each command
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_rsp.push_back(predict_command(cmd));
	end

	// check every response against the oldest expectation
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$error("response with nothing expected");
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				n_checked++;
				if (result.target_rate !== e.target_rate) begin
					$error("target_rate exp %0d got %0d", e.target_rate, result.target_rate);
					errors++;
				end
				if (result.big_flows !== e.big_flows) begin
					$error("big_flows exp %0d got %0d", e.big_flows, result.big_flows);
					errors++;
				end
				if (result.small_flows !== e.small_flows) begin
					$error("small_flows exp %0d got %0d", e.small_flows, result.small_flows);
					errors++;
				end
				if (result.saturated_flows !== e.saturated_flows) begin
					$error("saturated_flows exp %0d got %0d", e.saturated_flows,
						result.saturated_flows);
					errors++;
				end
				if (result.unused_total !== e.unused_total) begin
					$error("unused_total exp %0d got %0d", e.unused_total, result.unused_total);
					errors++;
				end
				if (result.action !== e.action) begin
					$error("action exp %0d got %0d", e.action, result.action);
					errors++;
				end
				if (result.share !== e.share) begin
					$error("share exp %0d got %0d", e.share, result.share);
					errors++;
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL flow_rate_target_allocator");
			$finish;
		end
	end

	// wait until every queued command is accepted and answered
	task automatic drain();
		while (cmd_queue.size() > 0 || start || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LINK_CAPACITY) p_capacity = value[15:0];
		else if (idx == CFG_MARGIN) p_margin = value[11:0];
	endtask

	// one allocation period: updates, maybe a join, then a tick and some reads
	task automatic queue_period();
		int n;
		n = $urandom_range(2, 10);
		for (int k = 0; k < n; k++)
			cmd_queue.push_back(make_cmd(OP_UPDATE, $urandom_range(0, 15),
				$urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0, pick_rate()));
		if ($urandom_range(0, 3) == 0)
			cmd_queue.push_back(make_cmd(OP_JOIN, $urandom_range(0, 63), $urandom, $urandom,
				$urandom_range(0, 65535)));
		cmd_queue.push_back(make_cmd(OP_TICK, $urandom_range(0, 63), $urandom, $urandom,
			$urandom_range(0, 65535)));
		n = $urandom_range(1, 4);
		for (int k = 0; k < n; k++)
			cmd_queue.push_back(make_cmd(OP_READ, $urandom_range(0, 63), $urandom, $urandom,
				$urandom_range(0, 65535)));
	endtask

	initial begin
		int caps[4];
		int margins[4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		for (int i = 0; i < NF; i++) begin
			p_active[i] = 0; p_small[i] = 0; p_meas[i] = 0; p_tgt[i] = TARGET_RESET;
		end
		p_eq_pending = 0;
		p_capacity = TARGET_RESET;
		p_margin = MARGIN_RESET;
		p_stats = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset-state reads, extremes, equalize, redistribute, no-big tick
		cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 63, 1, 1, 65535));
		cmd_queue.push_back(make_cmd(OP_UPDATE, 5, 1, 1, 100));
		cmd_queue.push_back(make_cmd(OP_JOIN, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_UPDATE, 0, 1, 0, 0));
		cmd_queue.push_back(make_cmd(OP_UPDATE, 63, 1, 0, 65535));
		cmd_queue.push_back(make_cmd(OP_UPDATE, 1, 1, 0, 12495));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 63, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 5, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 1, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_UPDATE, 63, 0, 1, 65535));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 63, 0, 0, 0));
		drain();

		// random phases across register settings, extremes included
		caps = '{65535, 1, 12500, 0};
		margins = '{0, 4095, 10, 0};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_LINK_CAPACITY, (ph == 3) ? $urandom_range(1, 65535) : caps[ph]);
			write_reg(CFG_MARGIN, (ph == 3) ? $urandom_range(0, 4095) : margins[ph]);
			while (cmd_queue.size() < 100) begin
				if ($urandom_range(0, 9) == 0)
					cmd_queue.push_back(make_cmd($urandom_range(0, 3), $urandom_range(0, 63),
						$urandom, $urandom, $urandom_range(0, 65535)));
				else
					queue_period();
			end
			if (ph == 3) stim_done = 1;
			drain();
		end

		// a few large-slot flows and a write to an unused register index
		write_reg(CFG_UNUSED_IDX, 16'h1234);
		write_reg(CFG_MARGIN, 4095);
		for (int k = 0; k < 8; k++)
			cmd_queue.push_back(make_cmd(OP_UPDATE, 32 + $urandom_range(0, 31), 1, 0,
				pick_rate()));
		cmd_queue.push_back(make_cmd(OP_JOIN, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_READ, 40, 0, 0, 0));
		drain();

		$display("checked %0d responses: %0d ticks, %0d equalized, %0d redistributed",
			n_checked, n_ticks, n_eq, n_redist);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("PASS flow_rate_target_allocator");
		else
			$display("FAIL flow_rate_target_allocator");
		$finish;
	end
endmodule

[files.f]
rtl/core/fra_pkg.sv
rtl/core/fra_ram.sv
rtl/core/flow_rate_target_allocator.sv
bench/flow_rate_target_allocator_tb.sv
